// File: hw/rtl/sfr_pkg.sv
// Shared types, line codes and CRC helper for the stuffed frame receiver.
package sfr_pkg;

   localparam int RX_BUFFER_BYTES = 256;
   localparam int COUNT_W = 9;
   localparam int ADDR_W = 3;

   localparam logic [7:0] CODE_START = 8'hFD;
   localparam logic [7:0] CODE_STOP = 8'hFE;
   localparam logic [7:0] CODE_STUFF = 8'hFF;
   localparam logic [7:0] STUFF_MAX = 8'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_GOOD = 16'h0F47;

   localparam logic [COUNT_W-1:0] MIN_PAYLOAD = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(RX_BUFFER_BYTES - 1);

   localparam logic [ADDR_W-1:0] REG_DEVICE_ADDRESS = ADDR_W'(0);

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_FRAME_GOOD = 3'd1,
      ST_CRC_ERROR = 3'd2,
      ST_BAD_STOP = 3'd3,
      ST_OUTSIDE = 3'd4,
      ST_STUFF_ERROR = 3'd5,
      ST_OVERFLOW = 3'd6,
      ST_ADDR_MISMATCH = 3'd7
   } status_type;

   typedef struct packed {
      logic in_frame;
      logic stuff_pending;
      logic address_seen;
      logic [COUNT_W-1:0] payload_count;
      logic [15:0] running_crc;
   } frame_state_type;

   localparam frame_state_type FRAME_IDLE = '{
      in_frame: 1'b0,
      stuff_pending: 1'b0,
      address_seen: 1'b0,
      payload_count: '0,
      running_crc: CRC_INIT
   };

   typedef struct packed {
      status_type status;
      logic data_valid;
      logic [7:0] data_byte;
      logic [COUNT_W-1:0] byte_index;
   } rsp_item_type;

   // Reflected CRC-16 update, one byte.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] w;
      w = {8'h00, b ^ crc[7:0]};
      for (int k = 0; k < 8; k++) begin
         if (w[0]) begin
            w = (w >> 1) ^ CRC_POLY;
         end else begin
            w = w >> 1;
         end
      end
      return w ^ {8'h00, crc[15:8]};
   endfunction

endpackage

// File: hw/rtl/sfr_if.sv
// Handshake channel interfaces for line bytes and status results.
interface sfr_req_if;
   logic valid;
   logic ready;
   logic [7:0] line_byte;

   modport source(output valid, output line_byte, input ready);
   modport sink(input valid, input line_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic data_valid;
   logic [7:0] data_byte;
   logic [8:0] byte_index;

   modport source(output valid, output status, output data_valid, output data_byte,
                  output byte_index, input ready);
   modport sink(input valid, input status, input data_valid, input data_byte,
                input byte_index, output ready);
endinterface

// File: hw/rtl/sfr_deframe.sv
// Frame state registers and the per-byte deframe, destuff and CRC step.
module sfr_deframe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           line_byte,
   input  logic [7:0]           device_address,
   output sfr_pkg::rsp_item_type result
);
   import sfr_pkg::*;

   frame_state_type state_ff;
   frame_state_type state_in;
   logic [7:0] value;
   logic fail;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRAME_IDLE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      value = line_byte;
      fail = 1'b0;
      result.status = ST_ACCEPTED;
      result.data_valid = 1'b0;
      result.data_byte = 8'h00;
      priority if (line_byte == CODE_START) begin
         state_in = FRAME_IDLE;
         state_in.in_frame = 1'b1;
      end else if (line_byte == CODE_STOP) begin
         if (state_ff.in_frame && state_ff.payload_count >= MIN_PAYLOAD) begin
            result.status = ((state_ff.running_crc ^ CRC_INIT) == CRC_GOOD)
                            ? ST_FRAME_GOOD : ST_CRC_ERROR;
         end else begin
            result.status = ST_BAD_STOP;
         end
         state_in = FRAME_IDLE;
      end else if (line_byte == CODE_STUFF) begin
         if (state_ff.in_frame) begin
            state_in.stuff_pending = 1'b1;
         end
      end else if (!state_ff.in_frame) begin
         result.status = ST_OUTSIDE;
      end else begin
         if (state_ff.stuff_pending) begin
            if (line_byte > STUFF_MAX) begin
               fail = 1'b1;
               result.status = ST_STUFF_ERROR;
            end else begin
               state_in.stuff_pending = 1'b0;
               value = CODE_STUFF - line_byte;
            end
         end
         if (!fail) begin
            if (state_ff.address_seen) begin
               if (state_ff.payload_count >= COUNT_LIMIT) begin
                  fail = 1'b1;
                  result.status = ST_OVERFLOW;
               end else begin
                  state_in.payload_count = state_ff.payload_count + 1'b1;
                  result.data_valid = 1'b1;
                  result.data_byte = value;
               end
            end else if (device_address != 8'h00 && device_address != value) begin
               fail = 1'b1;
               result.status = ST_ADDR_MISMATCH;
            end else begin
               state_in.address_seen = 1'b1;
            end
         end
         if (fail) begin
            state_in = FRAME_IDLE;
         end else begin
            state_in.running_crc = crc_update(state_ff.running_crc, value);
         end
      end
      // Stop reports the count of the frame it closes; errors leave zero.
      result.byte_index = (line_byte == CODE_STOP) ? state_ff.payload_count
                                                   : state_in.payload_count;
   end

endmodule

// File: hw/rtl/stuffed_frame_receiver_crc16.sv
// Top level of the byte-stuffed frame receiver with CRC-16 check.
//
//   channel  | direction | handshake        | payload
//   req_chan | in        | valid/ready      | line_byte[7:0]
//   rsp_chan | out       | valid/ready      | status[2:0], data_valid, data_byte, byte_index
//   csr_*    | in        | APB, pready = 1  | device_address at byte address 0
//
// Throughput is one line byte per clock while rsp_chan is ready; an accepted byte moves from the
// input register to the result register, with the whole deframe step and byte-wide CRC update between them.
// Reset is synchronous and active high; it clears the frame state, the pipeline
// valids and device_address. A stalled result holds in the result register while
// one more byte waits in the input register; ready drops only when both are full.
module stuffed_frame_receiver_crc16 (
   input  logic                        clock,
   input  logic                        reset,
   sfr_req_if.sink                     req_chan,
   sfr_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sfr_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import sfr_pkg::*;

   // Input stage: one line byte waiting for the step logic.
   logic s1_valid_ff;
   logic s1_valid_in;
   logic [7:0] s1_byte_ff;

   // Result stage.
   logic out_valid_ff;
   logic out_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type step_result;

   logic [7:0] device_address_ff;
   logic advance;
   logic req_take;
   logic csr_write;

   // Advance the input byte when the result register is free or being drained.
   assign advance = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on transaction, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.line_byte;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   sfr_deframe u_deframe (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .line_byte      (s1_byte_ff),
      .device_address (device_address_ff),
      .result         (step_result)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.status = rsp_ff.status;
   assign rsp_chan.data_valid = rsp_ff.data_valid;
   assign rsp_chan.data_byte = rsp_ff.data_byte;
   assign rsp_chan.byte_index = rsp_ff.byte_index;

   // Configuration port: single register, writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'h00;
      end else if (csr_write && csr_paddr[ADDR_W-1:2] == REG_DEVICE_ADDRESS[ADDR_W-1:2]) begin
         device_address_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[ADDR_W-1:2] == REG_DEVICE_ADDRESS[ADDR_W-1:2])
                       ? {24'h000000, device_address_ff} : 32'h00000000;

   // Payload bytes come out only with an accepted status and a nonzero count.
   a_data_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ff.data_valid |-> rsp_ff.status == ST_ACCEPTED &&
                                            rsp_ff.byte_index != '0)
      else $error("payload byte with bad status or zero index");

   // Errors that drop the frame report a zero index.
   a_error_index: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (rsp_ff.status == ST_STUFF_ERROR || rsp_ff.status == ST_OVERFLOW ||
                       rsp_ff.status == ST_ADDR_MISMATCH) |-> rsp_ff.byte_index == '0)
      else $error("frame error with nonzero index");

   // A stalled result must not be overwritten by the next step.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("result register overwritten while stalled");

   // The input stage advances exactly when a result is loaded.
   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced byte produced no result");

endmodule
